/* rtl/bilinear_grid_interpolator_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bilinear grid interpolator
// Shorthands for clocked checks that use clk and rst of the including module.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_GRID_INTERPOLATOR_CORE_ASSERT_SVH
`define BILINEAR_GRID_INTERPOLATOR_CORE_ASSERT_SVH

// same-cycle implication
`define BGI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BGI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/bgi_pkg.sv */
// ----------------------------------------------------------------------------
// bgi_pkg
// Types and constants shared by the bilinear grid interpolator modules.
// ----------------------------------------------------------------------------
package bgi_pkg;

  localparam int DEF_MAX_X_POINTS = 16;
  localparam int DEF_MAX_Y_POINTS = 4;

  localparam int VAL_W      = 32;
  localparam int ROW_W      = 4;
  localparam int COL_W      = 2;
  localparam int REQ_W      = 2;
  localparam int XCFG_W     = 5;
  localparam int YCFG_W     = 3;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_X_POINTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_POINTS = 1'b1;

  localparam logic [XCFG_W-1:0] X_POINTS_RESET = 5'd16;
  localparam logic [YCFG_W-1:0] Y_POINTS_RESET = 3'd4;

  localparam int QUEUE_DEPTH = 2;

  // quotient bits resolved by the serial divider
  localparam int DIV_STEPS = 35;
  localparam int PROD_W    = 66;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_X = 2'd0,
    REQ_LOAD_Y = 2'd1,
    REQ_LOAD_Z = 2'd2,
    REQ_QUERY  = 2'd3
  } req_t;

  typedef struct packed {
    req_t                    op;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] qx;
    logic signed [VAL_W-1:0] qy;
  } queue_entry_t;

  typedef struct packed {
    logic signed [VAL_W:0]   d;
    logic signed [VAL_W:0]   w;
    logic signed [VAL_W-1:0] z0;
    logic signed [VAL_W-1:0] z1;
  } lerp_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [VAL_W-1:0] value;
    logic                    sat;
  } lerp_rsp_t;

  typedef enum logic [2:0] {
    L_IDLE,
    L_MUL,
    L_ADD,
    L_PRE,
    L_DIV,
    L_FIN
  } lerp_state_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_XRD,
    B_XCMP,
    B_YRD,
    B_YCMP,
    B_F0,
    B_F1,
    B_F2,
    B_F3,
    B_F4,
    B_CHK,
    B_LA,
    B_LAW,
    B_LB,
    B_LBW,
    B_LC,
    B_LCW
  } back_state_t;

endpackage

/* rtl/bgi_front.sv */
// ----------------------------------------------------------------------------
// bgi_front
// Accepts requests, drops loads aimed beyond the stores, queues the rest.
// ----------------------------------------------------------------------------
module bgi_front #(
  parameter int MAX_X_POINTS = bgi_pkg::DEF_MAX_X_POINTS,
  parameter int MAX_Y_POINTS = bgi_pkg::DEF_MAX_Y_POINTS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [bgi_pkg::REQ_W-1:0]      req_type,
  input  logic [bgi_pkg::ROW_W-1:0]      row_index,
  input  logic [bgi_pkg::COL_W-1:0]      col_index,
  input  logic signed [bgi_pkg::VAL_W-1:0] load_value,
  input  logic signed [bgi_pkg::VAL_W-1:0] query_x,
  input  logic signed [bgi_pkg::VAL_W-1:0] query_y,
  output logic                           head_valid,
  output bgi_pkg::queue_entry_t          head,
  input  logic                           pop
);
  import bgi_pkg::*;

  localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNW = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t   entries [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CNW-1:0] count;
  logic           accept;
  logic           keep;
  logic           push;
  req_t           op;
  queue_entry_t   incoming;

  assign op     = req_t'(req_type);
  assign busy   = (count == CNW'(QUEUE_DEPTH));
  assign accept = start && !busy;

  always_comb begin
    case (op)
      REQ_LOAD_X: keep = int'(row_index) < MAX_X_POINTS;
      REQ_LOAD_Y: keep = int'(col_index) < MAX_Y_POINTS;
      REQ_LOAD_Z: keep = (int'(row_index) < MAX_X_POINTS) && (int'(col_index) < MAX_Y_POINTS);
      REQ_QUERY:  keep = 1'b1;
      default:    keep = 1'b0;
    endcase
  end

  assign push = accept && keep;

  always_comb begin
    incoming.op    = op;
    incoming.row   = row_index;
    incoming.col   = col_index;
    incoming.value = load_value;
    incoming.qx    = query_x;
    incoming.qy    = query_y;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNW'(1);
      end else if (pop && !push) begin
        count <= count - CNW'(1);
      end
    end
  end

  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

endmodule

/* rtl/bgi_lerp.sv */
// ----------------------------------------------------------------------------
// bgi_lerp
// One linear step z0 + d*(z1-z0)/w, rounded half away from zero, clipped.
// ----------------------------------------------------------------------------
module bgi_lerp (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  bgi_pkg::lerp_req_t req,
  output bgi_pkg::lerp_rsp_t rsp
);
  import bgi_pkg::*;

  localparam int RW = VAL_W + 1;
  localparam int CW = $clog2(DIV_STEPS + 1);
  localparam logic [DIV_STEPS-1:0] Q_CAP = DIV_STEPS'(1) << (DIV_STEPS - 1);

  lerp_state_t state;
  lerp_state_t state_next;

  logic [RW-1:0]          ud;
  logic [RW-1:0]          udz;
  logic [RW-1:0]          uw;
  logic                   neg;
  logic signed [VAL_W-1:0] z0;
  logic [PROD_W-1:0]      prod;
  logic [PROD_W-1:0]      num;
  logic [RW-1:0]          rem;
  logic [DIV_STEPS-1:0]   qsh;
  logic [CW-1:0]          cnt;

  logic signed [RW-1:0]   dz;
  logic [RW:0]            remsh;
  logic                   ge;
  logic [DIV_STEPS-1:0]   qc;
  logic signed [VAL_W+3:0] sum;
  logic                   hi_ge;

  assign dz    = {req.z1[VAL_W-1], req.z1} - {req.z0[VAL_W-1], req.z0};
  assign remsh = {rem, qsh[DIV_STEPS-1]};
  assign ge    = remsh >= {1'b0, uw};
  assign hi_ge = RW'(num[PROD_W-1:DIV_STEPS]) >= uw;
  assign qc    = (qsh > Q_CAP) ? Q_CAP : qsh;
  assign sum   = {{4{z0[VAL_W-1]}}, z0}
               + (neg ? -$signed({1'b0, qc}) : $signed({1'b0, qc}));

  always_comb begin
    state_next = state;
    case (state)
      L_IDLE:  if (start) state_next = L_MUL;
      L_MUL:   state_next = L_ADD;
      L_ADD:   state_next = L_PRE;
      L_PRE:   state_next = hi_ge ? L_FIN : L_DIV;
      L_DIV:   if (cnt == CW'(DIV_STEPS - 1)) state_next = L_FIN;
      L_FIN:   state_next = L_IDLE;
      default: state_next = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      L_IDLE: begin
        ud  <= req.d[RW-1] ? RW'(-req.d) : RW'(req.d);
        udz <= dz[RW-1] ? RW'(-dz) : RW'(dz);
        uw  <= req.w[RW-1] ? RW'(-req.w) : RW'(req.w);
        neg <= req.d[RW-1] ^ dz[RW-1] ^ req.w[RW-1];
        z0  <= req.z0;
      end
      L_MUL: prod <= PROD_W'(ud) * PROD_W'(udz);
      L_ADD: num <= prod + PROD_W'(uw >> 1);
      L_PRE: begin
        if (hi_ge) begin
          qsh <= Q_CAP;
        end else begin
          rem <= RW'(num[PROD_W-1:DIV_STEPS]);
          qsh <= num[DIV_STEPS-1:0];
        end
        cnt <= '0;
      end
      L_DIV: begin
        rem <= ge ? RW'(remsh - {1'b0, uw}) : remsh[RW-1:0];
        qsh <= {qsh[DIV_STEPS-2:0], ge};
        cnt <= cnt + CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == L_FIN);
    end
    if (state == L_FIN) begin
      if (sum > $signed((VAL_W+4)'(32'sh7fffffff))) begin
        rsp.value <= 32'sh7fffffff;
        rsp.sat   <= 1'b1;
      end else if (sum < -$signed((VAL_W+4)'(36'sh080000000))) begin
        rsp.value <= 32'sh80000000;
        rsp.sat   <= 1'b1;
      end else begin
        rsp.value <= sum[VAL_W-1:0];
        rsp.sat   <= 1'b0;
      end
    end
  end

endmodule

/* rtl/bgi_back.sv */
// ----------------------------------------------------------------------------
// bgi_back
// Grid stores, cell search and the three-step blend sequencer.
// ----------------------------------------------------------------------------
module bgi_back #(
  parameter int MAX_X_POINTS = bgi_pkg::DEF_MAX_X_POINTS,
  parameter int MAX_Y_POINTS = bgi_pkg::DEF_MAX_Y_POINTS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [bgi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bgi_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              head_valid,
  input  bgi_pkg::queue_entry_t             head,
  output logic                              pop,
  output logic                              result_valid,
  output logic signed [bgi_pkg::VAL_W-1:0]  z_value,
  output logic                              saturated,
  output logic                              zero_width
);
  import bgi_pkg::*;

  `include "bilinear_grid_interpolator_core_assert.svh"

  localparam int XW  = $clog2(MAX_X_POINTS);
  localparam int YW  = $clog2(MAX_Y_POINTS);
  localparam int NW  = $clog2(MAX_X_POINTS * MAX_Y_POINTS);
  localparam int CXW = $clog2(MAX_X_POINTS + 1);
  localparam int CYW = $clog2(MAX_Y_POINTS + 1);

  back_state_t state;
  back_state_t state_next;

  logic [XCFG_W-1:0] x_cfg;
  logic [YCFG_W-1:0] y_cfg;
  logic [CXW-1:0]    nx;
  logic [CYW-1:0]    ny;

  logic signed [VAL_W-1:0] x_mem [MAX_X_POINTS];
  logic signed [VAL_W-1:0] y_mem [MAX_Y_POINTS];
  logic signed [VAL_W-1:0] z_mem [MAX_X_POINTS * MAX_Y_POINTS];
  logic [XW-1:0]           x_addr;
  logic [YW-1:0]           y_addr;
  logic [NW-1:0]           z_addr;
  logic signed [VAL_W-1:0] x_rd;
  logic signed [VAL_W-1:0] y_rd;
  logic signed [VAL_W-1:0] z_rd;

  logic signed [VAL_W-1:0] qx;
  logic signed [VAL_W-1:0] qy;
  logic [CXW-1:0]          jx;
  logic [CYW-1:0]          jy;
  logic [CXW-1:0]          il_w;
  logic [CYW-1:0]          jl_w;
  logic [XW-1:0]           il;
  logic [YW-1:0]           jl;
  logic [XW-1:0]           il_p1;
  logic [YW-1:0]           jl_p1;

  logic signed [VAL_W-1:0] x0, x1, y0, y1;
  logic signed [VAL_W-1:0] z00, z10, z01, z11;
  logic signed [VAL_W-1:0] lowrow;
  logic signed [VAL_W-1:0] highrow;
  logic                    sat_acc;
  logic signed [VAL_W:0]   wd;
  logic signed [VAL_W:0]   hd;
  logic signed [VAL_W:0]   dx;
  logic signed [VAL_W:0]   dy;
  logic                    x_hit;
  logic                    y_hit;
  logic                    is_query;

  logic      lerp_start;
  lerp_req_t lerp_req;
  lerp_rsp_t lerp_rsp;

  function automatic logic [NW-1:0] node_addr(input logic [XW-1:0] r, input logic [YW-1:0] c);
    return NW'(int'(r) * MAX_Y_POINTS + int'(c));
  endfunction

  bgi_lerp u_lerp (
    .clk   (clk),
    .rst   (rst),
    .start (lerp_start),
    .req   (lerp_req),
    .rsp   (lerp_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      x_cfg <= X_POINTS_RESET;
      y_cfg <= Y_POINTS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_X_POINTS: x_cfg <= cfg_data[XCFG_W-1:0];
        CFG_Y_POINTS: y_cfg <= cfg_data[YCFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (x_cfg < XCFG_W'(2)) begin
      nx = CXW'(2);
    end else if (int'(x_cfg) > MAX_X_POINTS) begin
      nx = CXW'(MAX_X_POINTS);
    end else begin
      nx = CXW'(x_cfg);
    end
    if (y_cfg < YCFG_W'(2)) begin
      ny = CYW'(2);
    end else if (int'(y_cfg) > MAX_Y_POINTS) begin
      ny = CYW'(MAX_Y_POINTS);
    end else begin
      ny = CYW'(y_cfg);
    end
  end

  always_comb begin
    if (jx == '0) begin
      il_w = '0;
    end else if (jx == nx) begin
      il_w = nx - CXW'(2);
    end else begin
      il_w = jx - CXW'(1);
    end
    if (jy == '0) begin
      jl_w = '0;
    end else if (jy == ny) begin
      jl_w = ny - CYW'(2);
    end else begin
      jl_w = jy - CYW'(1);
    end
  end

  assign il       = il_w[XW-1:0];
  assign jl       = jl_w[YW-1:0];
  assign il_p1    = il + XW'(1);
  assign jl_p1    = jl + YW'(1);
  assign x_hit    = qx >= x_rd;
  assign y_hit    = qy >= y_rd;
  assign is_query = head_valid && (head.op == REQ_QUERY);
  assign wd       = {x1[VAL_W-1], x1} - {x0[VAL_W-1], x0};
  assign hd       = {y1[VAL_W-1], y1} - {y0[VAL_W-1], y0};
  assign dx       = {qx[VAL_W-1], qx} - {x0[VAL_W-1], x0};
  assign dy       = {qy[VAL_W-1], qy} - {y0[VAL_W-1], y0};

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (is_query) state_next = B_XRD;
      B_XRD:   state_next = B_XCMP;
      B_XCMP:  state_next = (x_hit && ((jx + CXW'(1)) < nx)) ? B_XRD : B_YRD;
      B_YRD:   state_next = B_YCMP;
      B_YCMP:  state_next = (y_hit && ((jy + CYW'(1)) < ny)) ? B_YRD : B_F0;
      B_F0:    state_next = B_F1;
      B_F1:    state_next = B_F2;
      B_F2:    state_next = B_F3;
      B_F3:    state_next = B_F4;
      B_F4:    state_next = B_CHK;
      B_CHK:   state_next = ((wd == '0) || (hd == '0)) ? B_IDLE : B_LA;
      B_LA:    state_next = B_LAW;
      B_LAW:   if (lerp_rsp.done) state_next = B_LB;
      B_LB:    state_next = B_LBW;
      B_LBW:   if (lerp_rsp.done) state_next = B_LC;
      B_LC:    state_next = B_LCW;
      B_LCW:   if (lerp_rsp.done) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop         = 1'b0;
    x_addr      = il;
    y_addr      = jl;
    z_addr      = node_addr(il, jl);
    lerp_start  = 1'b0;
    lerp_req.d  = dx;
    lerp_req.w  = wd;
    lerp_req.z0 = z00;
    lerp_req.z1 = z10;
    case (state)
      B_IDLE: pop = head_valid;
      B_XRD:  x_addr = jx[XW-1:0];
      B_YRD:  y_addr = jy[YW-1:0];
      B_F1: begin
        x_addr = il_p1;
        y_addr = jl_p1;
        z_addr = node_addr(il_p1, jl);
      end
      B_F2:   z_addr = node_addr(il, jl_p1);
      B_F3:   z_addr = node_addr(il_p1, jl_p1);
      B_LA:   lerp_start = 1'b1;
      B_LB: begin
        lerp_start  = 1'b1;
        lerp_req.z0 = z01;
        lerp_req.z1 = z11;
      end
      B_LC: begin
        lerp_start  = 1'b1;
        lerp_req.d  = dy;
        lerp_req.w  = hd;
        lerp_req.z0 = lowrow;
        lerp_req.z1 = highrow;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (head.op == REQ_LOAD_X)) begin
      x_mem[XW'(head.row)] <= head.value;
    end
    x_rd <= x_mem[x_addr];
  end

  always_ff @(posedge clk) begin
    if (pop && (head.op == REQ_LOAD_Y)) begin
      y_mem[YW'(head.col)] <= head.value;
    end
    y_rd <= y_mem[y_addr];
  end

  always_ff @(posedge clk) begin
    if (pop && (head.op == REQ_LOAD_Z)) begin
      z_mem[node_addr(XW'(head.row), YW'(head.col))] <= head.value;
    end
    z_rd <= z_mem[z_addr];
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        qx      <= head.qx;
        qy      <= head.qy;
        jx      <= '0;
        jy      <= '0;
        sat_acc <= 1'b0;
      end
      B_XCMP: if (x_hit) jx <= jx + CXW'(1);
      B_YCMP: if (y_hit) jy <= jy + CYW'(1);
      B_F1: begin
        x0  <= x_rd;
        y0  <= y_rd;
        z00 <= z_rd;
      end
      B_F2: begin
        x1  <= x_rd;
        y1  <= y_rd;
        z10 <= z_rd;
      end
      B_F3: z01 <= z_rd;
      B_F4: z11 <= z_rd;
      B_LAW: begin
        if (lerp_rsp.done) begin
          lowrow  <= lerp_rsp.value;
          sat_acc <= sat_acc | lerp_rsp.sat;
        end
      end
      B_LBW: begin
        if (lerp_rsp.done) begin
          highrow <= lerp_rsp.value;
          sat_acc <= sat_acc | lerp_rsp.sat;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ((state == B_CHK) && ((wd == '0) || (hd == '0)))
                   || ((state == B_LCW) && lerp_rsp.done);
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_CHK) begin
      z_value    <= '0;
      saturated  <= 1'b0;
      zero_width <= 1'b1;
    end else if ((state == B_LCW) && lerp_rsp.done) begin
      z_value    <= lerp_rsp.value;
      saturated  <= sat_acc | lerp_rsp.sat;
      zero_width <= 1'b0;
    end
  end

  `BGI_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid, "result strobe held twice")
  `BGI_ASSERT_SAME(a_zero_width_clean, result_valid && zero_width, (z_value == '0) && !saturated, "zero width result not clean")
  `BGI_ASSERT_SAME(a_search_bound, state == B_XCMP, jx < nx, "x search ran past the used points")
  `BGI_ASSERT_SAME(a_lerp_expected, lerp_rsp.done, (state == B_LAW) || (state == B_LBW) || (state == B_LCW), "blend step finished unexpectedly")

endmodule

/* rtl/bilinear_grid_interpolator_core.sv */
// ----------------------------------------------------------------------------
// bilinear_grid_interpolator_core
// Bilinear interpolation on a loaded rectilinear grid, signed Q16.16.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; a two-entry queue
// lets up to two requests wait while one is worked on. A load is written
// into its store as it is popped. A query walks the x and then the y
// breakpoints, reading and then comparing each one, reads the four corners
// and checks the cell; a cell of zero width or height gives a zero result
// flagged by zero_width, else three blend steps run on one shared unit with
// a one-bit-per-cycle divider, whose division is skipped when the quotient
// is clipped early. The result appears for exactly one cycle with
// result_valid and cannot be held off; the receiver must take it then.
// Configuration may be written only while no request is open.
module bilinear_grid_interpolator_core #(
  parameter int MAX_X_POINTS = bgi_pkg::DEF_MAX_X_POINTS,
  parameter int MAX_Y_POINTS = bgi_pkg::DEF_MAX_Y_POINTS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [bgi_pkg::REQ_W-1:0]         req_type,
  input  logic [bgi_pkg::ROW_W-1:0]         row_index,
  input  logic [bgi_pkg::COL_W-1:0]         col_index,
  input  logic signed [bgi_pkg::VAL_W-1:0]  load_value,
  input  logic signed [bgi_pkg::VAL_W-1:0]  query_x,
  input  logic signed [bgi_pkg::VAL_W-1:0]  query_y,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bgi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bgi_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              result_valid,
  output logic signed [bgi_pkg::VAL_W-1:0]  z_value,
  output logic                              saturated,
  output logic                              zero_width
);
  import bgi_pkg::*;

  queue_entry_t head;
  logic         head_valid;
  logic         pop;

  assign cfg_ready = 1'b1;

  bgi_front #(
    .MAX_X_POINTS (MAX_X_POINTS),
    .MAX_Y_POINTS (MAX_Y_POINTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .row_index  (row_index),
    .col_index  (col_index),
    .load_value (load_value),
    .query_x    (query_x),
    .query_y    (query_y),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  bgi_back #(
    .MAX_X_POINTS (MAX_X_POINTS),
    .MAX_Y_POINTS (MAX_Y_POINTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .z_value      (z_value),
    .saturated    (saturated),
    .zero_width   (zero_width)
  );

endmodule
